>>> rtl/smt_pkg.sv
// Package for the sorted multiset table: operation and status codes, write-port word type.
package smt_pkg;

    localparam int KEY_W  = 32;
    localparam int MULT_W = 16;
    localparam int OP_W   = 4;
    localparam int STAT_W = 2;

    localparam logic [MULT_W-1:0] MULT_MAX = '1;

    localparam logic [OP_W-1:0] OP_INSERT  = 4'd0;
    localparam logic [OP_W-1:0] OP_ERASE1  = 4'd1;
    localparam logic [OP_W-1:0] OP_ERASEK  = 4'd2;
    localparam logic [OP_W-1:0] OP_COUNT   = 4'd3;
    localparam logic [OP_W-1:0] OP_MIN     = 4'd4;
    localparam logic [OP_W-1:0] OP_MAX     = 4'd5;
    localparam logic [OP_W-1:0] OP_POPMIN  = 4'd6;
    localparam logic [OP_W-1:0] OP_POPMAX  = 4'd7;
    localparam logic [OP_W-1:0] OP_LT      = 4'd8;
    localparam logic [OP_W-1:0] OP_LEQ     = 4'd9;
    localparam logic [OP_W-1:0] OP_GT      = 4'd10;
    localparam logic [OP_W-1:0] OP_GEQ     = 4'd11;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // One write into the entry store
    typedef struct packed {
        logic              we;
        logic [KEY_W-1:0]  key;
        logic [MULT_W-1:0] cnt;
    } smt_wr_t;

endpackage

>>> rtl/smt_mem.sv
// Entry store: key and copy count per slot, one write and one registered read per cycle.
module smt_mem
    import smt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  smt_wr_t           wr,
    input  logic [AW-1:0]     waddr,
    input  logic [AW-1:0]     raddr,
    output logic [KEY_W-1:0]  rkey,
    output logic [MULT_W-1:0] rcnt
);

    logic [KEY_W-1:0]  key_mem [DEPTH];
    logic [MULT_W-1:0] cnt_mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            key_mem[waddr] <= wr.key;
            cnt_mem[waddr] <= wr.cnt;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rkey <= key_mem[raddr];
        rcnt <= cnt_mem[raddr];
    end

endmodule

>>> rtl/sorted_multiset_table.sv
// Top level of the sorted multiset table: search and shift sequencer around the entry store.
//
// Usage: drive operation, key and amount and raise start while busy is low; the
// word is taken at that clock edge and busy rises. When the request finishes, done
// is high for exactly one cycle with value, multiplicity and status valid; the
// receiver cannot stall, so it must take the word in that cycle. busy is already
// low in the done cycle, so a new start may be given there.
// A binary search over the occupied entries runs step by step (memory read, then
// compare), followed by a fetch and evaluation of the chosen entry. An insert of
// a new key or a removal of a key then moves each entry above it by one slot
// through the entry store, a read then a write per moved entry. One request at a
// time.
// Reset clears the occupancy count and the sequencer; the entry store is not
// cleared, since only entries below the occupancy count are ever used.
module sorted_multiset_table
    import smt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [MULT_W-1:0]        amount,
    output logic                     done,
    output logic signed [KEY_W-1:0]  value,
    output logic [MULT_W-1:0]        multiplicity,
    output logic [STAT_W-1:0]        status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           occ_reg, occ_next;
    logic [CW-1:0]           lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    hit_reg, hit_next;
    logic [CW-1:0]           j_reg, j_next;
    logic                    up_reg, up_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [MULT_W-1:0]       amt_reg, amt_next;
    logic                    done_reg, done_next;
    logic signed [KEY_W-1:0] val_reg, val_next;
    logic [MULT_W-1:0]       mult_reg, mult_next;
    logic [STAT_W-1:0]       stat_reg, stat_next;

    smt_wr_t           wr;
    logic [AW-1:0]     waddr, raddr;
    logic [KEY_W-1:0]  rkey;
    logic [MULT_W-1:0] rcnt;

    smt_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem
    (
        .clk   (clk),
        .wr    (wr),
        .waddr (waddr),
        .raddr (raddr),
        .rkey  (rkey),
        .rcnt  (rcnt)
    );

    // search helpers: midpoint and the shared compare
    logic [CW:0]   mid_sum;
    logic          strict;
    logic          go_right;
    logic          present;
    logic [MULT_W-1:0] take_n;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign strict   = (op_reg == OP_LEQ) || (op_reg == OP_GT);
    assign go_right = strict ? ($signed(rkey) <= key_reg) : ($signed(rkey) < key_reg);
    assign present  = hit_reg && ($signed(rkey) == key_reg);
    assign take_n   = (op_reg == OP_ERASE1) ? MULT_W'(1) : amt_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        j_next     = j_reg;
        up_next    = up_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        amt_next   = amt_reg;
        done_next  = 1'b0;
        val_next   = val_reg;
        mult_next  = mult_reg;
        stat_next  = stat_reg;
        wr         = '0;
        waddr      = '0;
        raddr      = mid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    key_next   = key;
                    amt_next   = amount;
                    lo_next    = '0;
                    hi_next    = occ_reg;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                if (lo_reg < hi_reg)
                begin
                    raddr      = mid_sum[AW:1];
                    mid_next   = mid_sum[AW:1];
                    state_next = S_SCMP;
                end
                else
                begin
                    // lo_reg is the bound; pick the entry this request looks at
                    case (op_reg)
                        OP_INSERT, OP_ERASE1, OP_ERASEK, OP_COUNT, OP_GT, OP_GEQ:
                        begin
                            idx_next = lo_reg;
                            hit_next = lo_reg < occ_reg;
                        end
                        OP_MIN, OP_POPMIN:
                        begin
                            idx_next = '0;
                            hit_next = occ_reg != '0;
                        end
                        OP_MAX, OP_POPMAX:
                        begin
                            idx_next = occ_reg - CW'(1);
                            hit_next = occ_reg != '0;
                        end
                        OP_LT, OP_LEQ:
                        begin
                            idx_next = lo_reg - CW'(1);
                            hit_next = lo_reg != '0;
                        end
                        default:
                        begin
                            idx_next = '0;
                            hit_next = 1'b0;
                        end
                    endcase
                    raddr      = idx_next[AW-1:0];
                    state_next = S_EVAL;
                end
            end
            S_SCMP:
            begin
                if (go_right)
                    lo_next = CW'(mid_reg) + CW'(1);
                else
                    hi_next = CW'(mid_reg);
                state_next = S_SRD;
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                val_next   = '0;
                mult_next  = '0;
                stat_next  = ST_NONE;
                waddr      = idx_reg[AW-1:0];
                case (op_reg)
                    OP_INSERT:
                    begin
                        val_next = key_reg;
                        if (present)
                        begin
                            wr.we     = 1'b1;
                            wr.key    = rkey;
                            wr.cnt    = (rcnt == MULT_MAX) ? rcnt : rcnt + MULT_W'(1);
                            mult_next = wr.cnt;
                            stat_next = ST_OK;
                        end
                        else if (occ_reg == CAP_C)
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            mult_next  = MULT_W'(1);
                            stat_next  = ST_OK;
                            up_next    = 1'b1;
                            j_next     = occ_reg;
                            done_next  = 1'b0;
                            state_next = S_SHRD;
                        end
                    end
                    OP_ERASE1, OP_ERASEK:
                    begin
                        val_next = key_reg;
                        if (present)
                        begin
                            stat_next = ST_OK;
                            if (take_n >= rcnt)
                            begin
                                up_next    = 1'b0;
                                j_next     = idx_reg;
                                done_next  = 1'b0;
                                state_next = S_SHRD;
                            end
                            else
                            begin
                                wr.we     = 1'b1;
                                wr.key    = rkey;
                                wr.cnt    = rcnt - take_n;
                                mult_next = wr.cnt;
                            end
                        end
                    end
                    OP_COUNT:
                    begin
                        val_next  = key_reg;
                        mult_next = present ? rcnt : '0;
                        stat_next = ST_OK;
                    end
                    OP_MIN, OP_MAX, OP_LT, OP_LEQ, OP_GT, OP_GEQ:
                    begin
                        if (hit_reg)
                        begin
                            val_next  = $signed(rkey);
                            mult_next = rcnt;
                            stat_next = ST_OK;
                        end
                    end
                    OP_POPMIN, OP_POPMAX:
                    begin
                        if (hit_reg)
                        begin
                            val_next  = $signed(rkey);
                            stat_next = ST_OK;
                            if (rcnt <= MULT_W'(1))
                            begin
                                up_next    = 1'b0;
                                j_next     = idx_reg;
                                done_next  = 1'b0;
                                state_next = S_SHRD;
                            end
                            else
                            begin
                                wr.we     = 1'b1;
                                wr.key    = rkey;
                                wr.cnt    = rcnt - MULT_W'(1);
                                mult_next = wr.cnt;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SHRD:
            begin
                if (up_reg)
                begin
                    // make room: move entries up until the slot is free
                    if (j_reg > idx_reg)
                    begin
                        raddr      = AW'(j_reg - CW'(1));
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        wr.we      = 1'b1;
                        wr.key     = key_reg;
                        wr.cnt     = MULT_W'(1);
                        waddr      = idx_reg[AW-1:0];
                        occ_next   = occ_reg + CW'(1);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // close the gap: move entries down
                    if (({1'b0, j_reg} + (CW+1)'(1)) < {1'b0, occ_reg})
                    begin
                        raddr      = AW'(j_reg + CW'(1));
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        occ_next   = occ_reg - CW'(1);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SHWR:
            begin
                wr.we      = 1'b1;
                wr.key     = rkey;
                wr.cnt     = rcnt;
                waddr      = j_reg[AW-1:0];
                j_next     = up_reg ? j_reg - CW'(1) : j_reg + CW'(1);
                state_next = S_SHRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        j_reg    <= j_next;
        up_reg   <= up_next;
        op_reg   <= op_next;
        key_reg  <= key_next;
        amt_reg  <= amt_next;
        val_reg  <= val_next;
        mult_reg <= mult_next;
        stat_reg <= stat_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign value        = val_reg;
    assign multiplicity = mult_reg;
    assign status       = stat_reg;

    // checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_C)
        else $error("occupancy above capacity");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE)
        else $error("done without a request in flight");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && stat_reg == ST_FULL) |-> occ_reg == CAP_C)
        else $error("full status with free slots");

endmodule
